// ===== rtl/ils_pkg.sv =====
// Shared definitions for the indexed list store.
// Command and status codes, default sizes and the cell control struct.
// No dependencies.
`default_nettype none

package ils_pkg;

  localparam int unsigned DefaultCapacity  = 64;
  localparam int unsigned DefaultDataWidth = 32;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned PosW  = 7;
  localparam int unsigned ValW  = 32;
  localparam int unsigned StatW = 2;
  localparam int unsigned CntW  = 7;

  localparam logic [CmdW-1:0] CMD_PEEK      = 3'd0;
  localparam logic [CmdW-1:0] CMD_INSERT    = 3'd1;
  localparam logic [CmdW-1:0] CMD_REMOVE    = 3'd2;
  localparam logic [CmdW-1:0] CMD_PUSH_HEAD = 3'd3;
  localparam logic [CmdW-1:0] CMD_PUSH_TAIL = 3'd4;
  localparam logic [CmdW-1:0] CMD_POP_HEAD  = 3'd5;
  localparam logic [CmdW-1:0] CMD_POP_TAIL  = 3'd6;

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic shift_up;    // insert: cells above the slot take their lower neighbor
    logic shift_down;  // remove: cells at or above the slot take their upper neighbor
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ils_cell.sv =====
// One storage cell of the list row.
// Holds one element and moves it to or from its neighbors on insert and remove.
// Depends on ils_pkg.
`default_nettype none

module ils_cell #(
  parameter int unsigned DataWidth = 32,
  parameter int unsigned IdxWidth  = 6,
  parameter int unsigned Idx       = 0
) (
  input  wire                     clk_i,
  input  ils_pkg::cell_ctrl_t     ctrl_i,
  input  wire  [IdxWidth-1:0]     slot_i,
  input  wire  [DataWidth-1:0]    wr_value_i,
  input  wire  [DataWidth-1:0]    lower_i,
  input  wire  [DataWidth-1:0]    upper_i,
  output logic [DataWidth-1:0]    data_o,
  output logic [DataWidth-1:0]    rd_o
);
  import ils_pkg::*;

  localparam logic [IdxWidth-1:0] MyIdx = IdxWidth'(Idx);

  logic [DataWidth-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_up) begin
      if (MyIdx > slot_i) begin
        data_d = lower_i;
      end else if (MyIdx == slot_i) begin
        data_d = wr_value_i;
      end
    end else if (ctrl_i.shift_down && (MyIdx >= slot_i)) begin
      data_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // one-hot select onto the shared read bus
  assign rd_o   = (MyIdx == slot_i) ? data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_store_top.sv =====
// Indexed list store: top level with command decode, count and result register.
// Instantiates a row of ils_cell. Depends on ils_pkg.
//
// A bounded list addressed by 1-based position. A command is taken at every
// rising edge where start_i is high; busy_o stays low, so commands may come in
// every cycle. Its result appears on the result ports, marked by done_o, in the
// cycle after the command is taken, for exactly one cycle, and cannot be held
// off. The row of cells shifts all later elements up or down together, which
// sets the one-command-per-cycle rate; a command sees the list as
// left by the one before it. Errors (bad position, empty, full) leave the list
// untouched and return read_value_o of zero.
`default_nettype none

module indexed_list_store_top #(
  parameter int unsigned CAPACITY   = ils_pkg::DefaultCapacity,
  parameter int unsigned DATA_WIDTH = ils_pkg::DefaultDataWidth
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire  [ils_pkg::CmdW-1:0]     command_i,
  input  wire  [ils_pkg::PosW-1:0]     position_i,
  input  wire  [ils_pkg::ValW-1:0]     item_value_i,
  output logic                         done_o,
  output logic [ils_pkg::ValW-1:0]     read_value_o,
  output logic [ils_pkg::StatW-1:0]    status_o,
  output logic [ils_pkg::CntW-1:0]     element_count_o,
  output logic                         is_empty_o
);
  import ils_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned PW   = ((CW > PosW) ? CW : PosW) + 1;

  logic              accept;
  logic [CW-1:0]     count_q, count_d;

  logic [PW-1:0]     cnt_ext, pos_ext, p_eff, lim;
  logic              is_peek, is_ins, is_rem, in_range, full;
  logic [StatW-1:0]  status;
  logic              ok;
  logic [IdxW-1:0]   slot;
  cell_ctrl_t        ctrl;

  logic [DATA_WIDTH-1:0] wr_value;
  logic [DATA_WIDTH-1:0] rd_sel;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

  logic              done_q;
  logic [ValW-1:0]   rd_q;
  logic [StatW-1:0]  st_q;
  logic [CntW-1:0]   ec_q;
  logic              empty_q;

  assign busy_o = 1'b0;
  assign accept = start_i;

  assign cnt_ext  = PW'(count_q);
  assign pos_ext  = PW'(position_i);
  assign wr_value = DATA_WIDTH'(item_value_i);

  always_comb begin
    p_eff   = pos_ext;
    is_peek = 1'b0;
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    case (command_i)
      CMD_PEEK: begin
        is_peek = 1'b1;
      end
      CMD_INSERT: begin
        is_ins = 1'b1;
      end
      CMD_REMOVE: begin
        is_rem = 1'b1;
      end
      CMD_PUSH_HEAD: begin
        p_eff  = PW'(1);
        is_ins = 1'b1;
      end
      CMD_PUSH_TAIL: begin
        p_eff  = cnt_ext + PW'(1);
        is_ins = 1'b1;
      end
      CMD_POP_HEAD: begin
        p_eff  = PW'(1);
        is_rem = 1'b1;
      end
      CMD_POP_TAIL: begin
        p_eff  = cnt_ext;
        is_rem = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // insert may also target one past the last element
  assign lim      = is_ins ? (cnt_ext + PW'(1)) : cnt_ext;
  assign in_range = (p_eff != '0) && (p_eff <= lim);
  assign full     = (count_q == CW'(CAPACITY));

  always_comb begin
    status = ST_OK;
    if (is_peek || is_ins || is_rem) begin
      if (!in_range) begin
        status = ST_RANGE;
      end else if (is_ins && full) begin
        status = ST_FULL;
      end
    end
  end

  assign ok              = (status == ST_OK);
  assign slot            = IdxW'(p_eff - PW'(1));
  assign ctrl.shift_up   = accept && is_ins && ok;
  assign ctrl.shift_down = accept && is_rem && ok;

  always_comb begin
    count_d = count_q;
    if (ctrl.shift_up) begin
      count_d = count_q + CW'(1);
    end else if (ctrl.shift_down) begin
      count_d = count_q - CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower, upper;
    if (i == 0) begin : g_lo0
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hiN
      assign upper = '0;
    end else begin : g_hi
      assign upper = cell_data[i+1];
    end
    ils_cell #(
      .DataWidth (DATA_WIDTH),
      .IdxWidth  (IdxW),
      .Idx       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .slot_i     (slot),
      .wr_value_i (wr_value),
      .lower_i    (lower),
      .upper_i    (upper),
      .data_o     (cell_data[i]),
      .rd_o       (cell_rd[i])
    );
  end

  // AND-OR read bus: only the addressed cell drives nonzero
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q    <= (ok && (is_peek || is_rem)) ? ValW'(rd_sel) : '0;
      st_q    <= status;
      ec_q    <= CntW'(count_d);
      empty_q <= (count_d == '0);
    end
  end

  assign done_o          = done_q;
  assign read_value_o    = rd_q;
  assign status_o        = st_q;
  assign element_count_o = ec_q;
  assign is_empty_o      = empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("command transfer without result");

  a_error_keeps_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !ok |=> count_q == $past(count_q))
    else $error("failed command changed the count");

  a_error_zero_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> read_value_o == '0)
    else $error("nonzero read value on error");

  a_full_only_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_FULL) |-> count_q == CW'(CAPACITY))
    else $error("full status below capacity");

endmodule

`default_nettype wire

// ===== tb/ils_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for indexed_list_store_top: tracks the list contents, predicts
// one result per command transfer and compares it with the block's output.
// Depends on ils_pkg.

module ils_result_checker #(
  parameter int unsigned CAPACITY   = ils_pkg::DefaultCapacity,
  parameter int unsigned DATA_WIDTH = ils_pkg::DefaultDataWidth
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire                       busy_i,
  input  wire [ils_pkg::CmdW-1:0]   command_i,
  input  wire [ils_pkg::PosW-1:0]   position_i,
  input  wire [ils_pkg::ValW-1:0]   item_value_i,
  input  wire                       done_i,
  input  wire [ils_pkg::ValW-1:0]   read_value_i,
  input  wire [ils_pkg::StatW-1:0]  status_i,
  input  wire [ils_pkg::CntW-1:0]   element_count_i,
  input  wire                       is_empty_i,
  output int                        pending_o,
  output int                        list_size_o,
  output int                        fail_count_o,
  output int                        ok_count_o,
  output int                        range_count_o,
  output int                        full_count_o
);
  import ils_pkg::*;

  localparam logic [63:0] WideMask = (64'd1 << DATA_WIDTH) - 64'd1;

  typedef struct packed {
    logic [ValW-1:0]  value;
    logic [StatW-1:0] status;
    logic [CntW-1:0]  count;
    logic             empty;
  } list_result_t;

  logic [ValW-1:0] stored_q[$];
  list_result_t    awaited_q[$];
  int failures, n_ok, n_range, n_full;

  function automatic logic [StatW-1:0] insert_at(input int slot, input logic [ValW-1:0] val);
    if (slot < 1 || slot > stored_q.size() + 1) return ST_RANGE;
    // range test comes before the full test
    if (stored_q.size() >= CAPACITY) return ST_FULL;
    stored_q.insert(slot - 1, val & WideMask[ValW-1:0]);
    return ST_OK;
  endfunction

  function automatic logic [StatW-1:0] remove_at(input int slot,
                                                 output logic [ValW-1:0] val);
    val = '0;
    if (slot < 1 || slot > stored_q.size()) return ST_RANGE;
    val = stored_q[slot - 1];
    stored_q.delete(slot - 1);
    return ST_OK;
  endfunction

  function automatic list_result_t apply_command(input logic [CmdW-1:0] cmd,
                                                 input logic [PosW-1:0] pos,
                                                 input logic [ValW-1:0] val);
    list_result_t r;
    int slot;
    slot = int'(pos);
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PEEK: begin
        if (slot < 1 || slot > stored_q.size()) r.status = ST_RANGE;
        else r.value = stored_q[slot - 1];
      end
      CMD_INSERT:    r.status = insert_at(slot, val);
      CMD_REMOVE:    r.status = remove_at(slot, r.value);
      CMD_PUSH_HEAD: r.status = insert_at(1, val);
      CMD_PUSH_TAIL: r.status = insert_at(stored_q.size() + 1, val);
      CMD_POP_HEAD:  r.status = remove_at(1, r.value);
      CMD_POP_TAIL:  r.status = remove_at(stored_q.size(), r.value);
      default: ;  // unused code: no change
    endcase
    if (r.status != ST_OK) r.value = '0;
    r.count = CntW'(stored_q.size());
    r.empty = (stored_q.size() == 0);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [ValW-1:0] want,
                             input logic [ValW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      stored_q.delete();
      awaited_q.delete();
      failures = 0;
      n_ok = 0;
      n_range = 0;
      n_full = 0;
      pending_o     <= 0;
      list_size_o   <= 0;
      fail_count_o  <= 0;
      ok_count_o    <= 0;
      range_count_o <= 0;
      full_count_o  <= 0;
    end else begin
      // results first, so a command taken at this edge is not matched yet
      if (done_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %0h status %0h",
                   $time, read_value_i, status_i);
          failures++;
        end else begin
          want = awaited_q[0];
          awaited_q.delete(0);
          check_field("read_value", want.value, read_value_i);
          check_field("status", ValW'(want.status), ValW'(status_i));
          check_field("element_count", ValW'(want.count), ValW'(element_count_i));
          check_field("is_empty", ValW'(want.empty), ValW'(is_empty_i));
        end
      end
      if (start_i && !busy_i) begin
        want = apply_command(command_i, position_i, item_value_i);
        case (want.status)
          ST_OK:    n_ok++;
          ST_RANGE: n_range++;
          default:  n_full++;
        endcase
        awaited_q.insert(awaited_q.size(), want);
      end
      pending_o     <= awaited_q.size();
      list_size_o   <= stored_q.size();
      fail_count_o  <= failures;
      ok_count_o    <= n_ok;
      range_count_o <= n_range;
      full_count_o  <= n_full;
    end
  end

endmodule

// ===== tb/indexed_list_store_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top for indexed_list_store_top: clock, reset, command stimulus
// and verdict. Depends on ils_pkg and ils_result_checker.

module indexed_list_store_top_test;
  import ils_pkg::*;

  localparam int unsigned Capacity = DefaultCapacity;
  localparam logic [CmdW-1:0] CmdUnused = 3'd7;
  localparam int RandomItems = 900;
  localparam int IdleLimit   = 2000;

  localparam int KindGrow   = 0;
  localparam int KindShrink = 1;
  localparam int KindMix    = 2;
  localparam int KindNoise  = 3;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start_i = 1'b0;
  logic [CmdW-1:0] command_i = '0;
  logic [PosW-1:0] position_i = '0;
  logic [ValW-1:0] item_value_i = '0;

  logic             busy_o;
  logic             done_o;
  logic [ValW-1:0]  read_value_o;
  logic [StatW-1:0] status_o;
  logic [CntW-1:0]  element_count_o;
  logic             is_empty_o;

  int pending, list_size, fail_count, ok_count, range_count, full_count;
  int idle_cycles = 0;
  bit steady = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  indexed_list_store_top #(
    .CAPACITY   (Capacity),
    .DATA_WIDTH (DefaultDataWidth)
  ) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .position_i, .item_value_i,
    .done_o, .read_value_o, .status_o, .element_count_o, .is_empty_o
  );

  ils_result_checker #(
    .CAPACITY   (Capacity),
    .DATA_WIDTH (DefaultDataWidth)
  ) checker_i (
    .clk_i, .rst_ni, .start_i,
    .busy_i          (busy_o),
    .command_i, .position_i, .item_value_i,
    .done_i          (done_o),
    .read_value_i    (read_value_o),
    .status_i        (status_o),
    .element_count_i (element_count_o),
    .is_empty_i      (is_empty_o),
    .pending_o       (pending),
    .list_size_o     (list_size),
    .fail_count_o    (fail_count),
    .ok_count_o      (ok_count),
    .range_count_o   (range_count),
    .full_count_o    (full_count)
  );

  // watchdog: cycles without a command or result transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
          $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // mostly a valid 1-based slot up to hi, sometimes just past it or anywhere
  function automatic logic [PosW-1:0] pick_pos(input int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85 && hi >= 1) return PosW'($urandom_range(1, hi));
    if (r < 92) return PosW'(hi + 1);
    if (r < 96) return '0;
    return PosW'($urandom_range(0, 127));
  endfunction

  task automatic issue(input logic [CmdW-1:0] cmd, input logic [PosW-1:0] pos,
                       input logic [ValW-1:0] val);
    int gap;
    bit ready;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    command_i    <= cmd;
    position_i   <= pos;
    item_value_i <= val;
    do begin
      @(negedge clk_i);
      ready = !busy_o;
      @(posedge clk_i);
    end while (!ready);
  endtask

  task automatic random_item(input int kind);
    int r;
    logic [CmdW-1:0] cmd;
    r = $urandom_range(0, 9);
    case (kind)
      KindGrow: begin
        if (r < 4) issue(CMD_PUSH_TAIL, PosW'($urandom_range(0, 127)), pick_value());
        else if (r < 6) issue(CMD_PUSH_HEAD, PosW'($urandom_range(0, 127)), pick_value());
        else if (r < 9) issue(CMD_INSERT, pick_pos(list_size + 1), pick_value());
        else issue(CMD_PEEK, pick_pos(list_size), pick_value());
      end
      KindShrink: begin
        if (r < 2) issue(CMD_POP_HEAD, PosW'($urandom_range(0, 127)), $urandom);
        else if (r < 4) issue(CMD_POP_TAIL, PosW'($urandom_range(0, 127)), $urandom);
        else if (r < 8) issue(CMD_REMOVE, pick_pos(list_size), $urandom);
        else issue(CMD_PEEK, pick_pos(list_size), $urandom);
      end
      KindMix: begin
        cmd = CmdW'($urandom_range(0, 6));
        issue(cmd, pick_pos(cmd == CMD_INSERT ? list_size + 1 : list_size), pick_value());
      end
      default: begin
        if (r < 5) issue(CmdUnused, PosW'($urandom_range(0, 127)), $urandom);
        else issue(CmdW'($urandom_range(0, 6)), PosW'($urandom_range(0, 127)), $urandom);
      end
    endcase
  endtask

  initial begin
    int counted, kind, len;
    counted = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: every read-type command must report a range error
    issue(CMD_PEEK, 7'd1, 32'h0);
    issue(CMD_POP_HEAD, 7'd0, 32'h0);
    issue(CMD_POP_TAIL, 7'd0, 32'h0);
    issue(CMD_REMOVE, 7'd1, 32'h0);
    issue(CMD_INSERT, 7'd0, 32'hDEAD_BEEF);
    issue(CMD_INSERT, 7'd2, 32'hDEAD_BEEF);
    issue(CMD_INSERT, 7'd1, 32'hFFFF_FFFF);
    issue(CMD_PUSH_HEAD, 7'd127, 32'h0000_0000);
    issue(CMD_PUSH_TAIL, 7'd0, 32'hA5A5_A5A5);
    issue(CMD_PUSH_TAIL, 7'd64, 32'h5A5A_5A5A);
    // append at count+1, then a middle insert
    issue(CMD_INSERT, 7'd5, 32'h1234_5678);
    issue(CMD_INSERT, 7'd3, 32'h8765_4321);
    issue(CMD_PEEK, 7'd1, 32'h0);
    issue(CMD_PEEK, 7'd6, 32'h0);
    issue(CMD_PEEK, 7'd7, 32'h0);
    issue(CMD_PEEK, 7'd127, 32'h0);
    issue(CMD_PEEK, 7'd0, 32'h0);
    issue(CMD_REMOVE, 7'd3, 32'h0);
    issue(CMD_REMOVE, 7'd0, 32'h0);
    issue(CMD_REMOVE, 7'd127, 32'hFFFF_FFFF);
    issue(CmdUnused, 7'd127, 32'hFFFF_FFFF);
    issue(CMD_POP_HEAD, 7'd0, 32'h0);
    issue(CMD_POP_TAIL, 7'd0, 32'h0);

    // episodes: growth runs can fill the list, shrink runs can drain it
    while (counted < RandomItems) begin
      kind = $urandom_range(0, 9);
      steady = ($urandom_range(0, 2) == 0);
      if (kind <= 2) begin
        kind = KindGrow;
        len = $urandom_range(20, 90);
      end else if (kind <= 4) begin
        kind = KindShrink;
        len = $urandom_range(20, 80);
      end else if (kind <= 8) begin
        kind = KindMix;
        len = $urandom_range(10, 60);
      end else begin
        kind = KindNoise;
        len = $urandom_range(3, 10);
      end
      repeat (len) random_item(kind);
      if (kind != KindNoise) counted += len;
    end
    start_i <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);

    $display("covered %0d commands: %0d ok, %0d range or empty errors, %0d full rejects",
             ok_count + range_count + full_count, ok_count, range_count, full_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/indexed_list_store_top.sv
tb/ils_result_checker.sv
tb/indexed_list_store_top_test.sv
